// ----- rtl/core/ugl_pkg.sv -----
// ----------------------------------------------------------------------------
// ugl_pkg
// Shared types and constants of the glyph layout engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ugl_pkg;

	// Input commands.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_UTF8_MODE   = 2'd0;
	localparam logic [1:0] REG_LINE_HEIGHT = 2'd1;

	// Operations passed from the front end to the back end.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_PLACE = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	// Result kinds.
	localparam logic KIND_QUAD = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [20:0] CODE_NEWLINE = 21'd10;
	localparam int unsigned QUEUE_DEPTH  = 4;

	// One glyph table entry; hb holds height minus bearing_y.
	typedef struct packed {
		logic               visible;
		logic signed [11:0] advance;
		logic [9:0]         width;
		logic [9:0]         height;
		logic signed [10:0] bx;
		logic signed [11:0] hb;
	} glyph_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [20:0]        code;
		logic               in_range;
		logic [9:0]         slot;
		glyph_t             glyph;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} op_t;

endpackage

`default_nettype wire

// ----- rtl/core/ugl_front.sv -----
// ----------------------------------------------------------------------------
// ugl_front
// Classifies accepted words and gathers UTF-8 sequences into code points.
// ----------------------------------------------------------------------------
`default_nettype none

module ugl_front import ugl_pkg::*; #(
	parameter int GLYPH_ENTRIES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [1:0]         command,
	input  wire logic [9:0]         glyph_slot,
	input  wire logic               glyph_visible,
	input  wire logic signed [11:0] glyph_advance,
	input  wire logic [9:0]         glyph_width,
	input  wire logic [9:0]         glyph_height,
	input  wire logic signed [10:0] bearing_x,
	input  wire logic signed [10:0] bearing_y,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic [7:0]         text_byte,
	input  wire logic               utf8_mode,
	output      logic               push,
	output      op_t                entry
);

	logic [20:0] accum_q;
	logic [1:0]  pending_q;
	logic [20:0] accum_d;
	logic [1:0]  pending_d;
	logic [20:0] acc_next;
	logic [1:0]  pend_next;
	logic        emit;
	logic [1:0]  emit_op;
	logic [20:0] emit_code;

	assign acc_next  = {accum_q[14:0], text_byte[5:0]};
	assign pend_next = pending_q - 2'd1;

	always_comb begin
		accum_d   = accum_q;
		pending_d = pending_q;
		emit      = 1'b0;
		emit_op   = OP_PLACE;
		emit_code = 21'(text_byte);
		unique case (command)
			CMD_LOAD: begin
				emit    = (22'(glyph_slot) < 22'(GLYPH_ENTRIES));
				emit_op = OP_LOAD;
			end
			CMD_BEGIN: begin
				accum_d   = '0;
				pending_d = '0;
				emit      = 1'b1;
				emit_op   = OP_BEGIN;
			end
			CMD_TEXT: begin
				priority if (text_byte == 8'd0) begin
					accum_d   = '0;
					pending_d = '0;
					emit      = 1'b1;
					emit_op   = OP_END;
				end else if (!utf8_mode) begin
					accum_d   = '0;
					pending_d = '0;
					emit      = 1'b1;
				end else if (pending_q != 2'd0) begin
					pending_d = pend_next;
					if (pend_next == 2'd0) begin
						accum_d   = '0;
						emit      = 1'b1;
						emit_code = acc_next;
					end else begin
						accum_d = acc_next;
					end
				end else if (text_byte >= 8'hF0) begin
					accum_d   = 21'(text_byte & 8'h07);
					pending_d = 2'd3;
				end else if (text_byte >= 8'hE0) begin
					accum_d   = 21'(text_byte & 8'h0F);
					pending_d = 2'd2;
				end else if (text_byte >= 8'hC0) begin
					accum_d   = 21'(text_byte & 8'h1F);
					pending_d = 2'd1;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			pending_q <= '0;
		end else if (accept) begin
			accum_q   <= accum_d;
			pending_q <= pending_d;
		end
	end

	always_comb begin
		entry                = '0;
		entry.op             = emit_op;
		entry.code           = emit_code;
		entry.in_range       = (22'(emit_code) < 22'(GLYPH_ENTRIES));
		entry.slot           = glyph_slot;
		entry.start_x        = start_x;
		entry.start_y        = start_y;
		if (glyph_visible) begin
			entry.glyph.visible = 1'b1;
			entry.glyph.advance = glyph_advance;
			entry.glyph.width   = glyph_width;
			entry.glyph.height  = glyph_height;
			entry.glyph.bx      = bearing_x;
			entry.glyph.hb      = $signed({2'b00, glyph_height}) - 12'(bearing_y);
		end
	end

	assign push = accept && emit;

endmodule

`default_nettype wire

// ----- rtl/core/ugl_queue.sv -----
// ----------------------------------------------------------------------------
// ugl_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ugl_queue import ugl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_entry,
	output      logic full,
	input  wire logic pop,
	output      logic valid,
	output      op_t  head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	op_t           slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ugl_back.sv -----
// ----------------------------------------------------------------------------
// ugl_back
// Glyph table, pen state and quad placement with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugl_back import ugl_pkg::*; #(
	parameter int GLYPH_ENTRIES = 1024,
	parameter int COORD_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire op_t         q_head,
	output      logic        q_pop,
	input  wire logic [9:0]  line_height,
	output      logic        clearing,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        out_kind,
	output      logic [93:0] out_data
);

	localparam int IW  = $clog2(GLYPH_ENTRIES);
	localparam int C   = COORD_BITS;
	localparam int SW  = C + 1;
	localparam int XW  = ((C > 16) ? C : 16) + 1;
	localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

	function automatic logic signed [C-1:0] sat(input logic signed [SW-1:0] v);
		if (v > SW'(CMAX)) begin
			return CMAX;
		end else if (v < SW'(CMIN)) begin
			return CMIN;
		end
		return v[C-1:0];
	endfunction

	function automatic logic signed [C-1:0] sat_start(input logic signed [15:0] s);
		logic signed [XW-1:0] v;
		v = XW'(s);
		if (v > XW'(CMAX)) begin
			return CMAX;
		end else if (v < XW'(CMIN)) begin
			return CMIN;
		end
		return v[C-1:0];
	endfunction

	function automatic logic [15:0] to_port(input logic [C-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

	// Glyph table.
	glyph_t        mem [GLYPH_ENTRIES];
	glyph_t        rdata_q;
	logic          we;
	logic [IW-1:0] waddr;
	glyph_t        wdata;
	logic          re;

	logic          clr_busy_q;
	logic [IW-1:0] clr_cnt_q;

	// Stage one.
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [20:0]        code_s1;
	logic               inr_s1;
	logic signed [15:0] sx_s1;
	logic signed [15:0] sy_s1;

	logic signed [C-1:0] pen_x_q;
	logic signed [C-1:0] pen_y_q;
	logic signed [C-1:0] line_x_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [93:0] out_data_q;

	glyph_t              ent;
	logic                nl;
	logic                needs_out;
	logic                out_free;
	logic                fire_s1;
	logic signed [C-1:0] pxb;
	logic signed [C-1:0] pyb;
	logic signed [C-1:0] qx;
	logic signed [C-1:0] qy;
	logic signed [C-1:0] pxn;

	assign clearing = clr_busy_q;
	assign q_pop    = q_valid && !clr_busy_q && (!valid_s1 || fire_s1);
	assign re       = q_pop && (q_head.op == OP_PLACE);

	always_comb begin
		we    = 1'b0;
		waddr = IW'(q_head.slot);
		wdata = q_head.glyph;
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (q_pop && (q_head.op == OP_LOAD)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[q_head.code[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + IW'(1);
			if (clr_cnt_q == IW'(GLYPH_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Placement arithmetic.
	assign ent       = inr_s1 ? rdata_q : '0;
	assign nl        = (code_s1 == CODE_NEWLINE);
	assign out_free  = !out_valid_q || out_ready;
	assign needs_out = (op_s1 == OP_END) || ((op_s1 == OP_PLACE) && (ent.visible || nl));
	assign fire_s1   = valid_s1 && (!needs_out || out_free);

	assign pxb = nl ? line_x_q : pen_x_q;
	assign pyb = nl ? sat(SW'(pen_y_q) - SW'($signed({1'b0, line_height}))) : pen_y_q;
	assign qx  = sat(SW'(pxb) + SW'(ent.bx));
	assign qy  = sat(SW'(pyb) - SW'(ent.hb));
	assign pxn = sat(SW'(pxb) + SW'(ent.advance));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= (q_head.op != OP_LOAD);
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1   <= q_head.op;
			code_s1 <= q_head.code;
			inr_s1  <= q_head.in_range;
			sx_s1   <= q_head.start_x;
			sy_s1   <= q_head.start_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			line_x_q <= '0;
		end else if (fire_s1) begin
			if (op_s1 == OP_BEGIN) begin
				pen_x_q  <= sat_start(sx_s1);
				pen_y_q  <= sat_start(sy_s1);
				line_x_q <= sat_start(sx_s1);
			end else if (needs_out && (op_s1 == OP_PLACE)) begin
				pen_x_q <= pxn;
				pen_y_q <= pyb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && needs_out) begin
			if (op_s1 == OP_END) begin
				out_kind_q <= KIND_END;
				out_data_q <= {to_port(pen_y_q), to_port(pen_x_q), 62'd0};
			end else begin
				out_kind_q <= KIND_QUAD;
				out_data_q <= {to_port(pyb), to_port(pxn), ent.height, ent.width,
					to_port(qy), to_port(qx), code_s1[9:0]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_glyph_layout_top.sv -----
// ----------------------------------------------------------------------------
// utf8_glyph_layout_top
// Byte-serial text layout engine: glyph table, UTF-8 decoder and pen.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Contents
// s_axis    in         s_axis_tvalid/tready   command word (tuser) and fields
// m_axis    out        m_axis_tvalid/tready   quad or end word (tuser = kind)
// cfg       in         cfg_valid/cfg_ready    register index and write data
//
// One word is taken in every cycle while s_axis_tready is high and at most
// one result leaves every cycle while m_axis_tready is high; a text word
// reaches the output register via the queue, table read and placement stage.
// After reset the glyph table is cleared, one entry a cycle, during which
// s_axis_tready stays low; configuration is always taken.
// A stall at m_axis backs up through the placement stage into the queue, which
// holds four operations before the input side stops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_glyph_layout_top import ugl_pkg::*; #(
	parameter int GLYPH_ENTRIES = 1024,
	parameter int COORD_BITS    = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input words.
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	// From bit 0: glyph_slot, glyph_visible, glyph_advance, glyph_width,
	// glyph_height, bearing_x, bearing_y, start_x, start_y, text_byte, zero fill.
	input  wire logic [111:0] s_axis_tdata,
	// command.
	input  wire logic [1:0]   s_axis_tuser,
	// Result words.
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// From bit 0: glyph_code, quad_x, quad_y, quad_w, quad_h, pen_x, pen_y,
	// zero fill.
	output      logic [95:0]  m_axis_tdata,
	// kind.
	output      logic [0:0]   m_axis_tuser,
	// Configuration writes.
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [9:0]   cfg_data
);

	// Configuration registers.
	logic       utf8_mode_q;
	logic [9:0] line_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_mode_q   <= 1'b1;
			line_height_q <= 10'd16;
		end else if (cfg_valid) begin
			if (cfg_index == REG_UTF8_MODE) begin
				utf8_mode_q <= cfg_data[0];
			end else if (cfg_index == REG_LINE_HEIGHT) begin
				line_height_q <= cfg_data;
			end
		end
	end

	logic accept;
	logic push;
	op_t  push_entry;
	logic q_full;
	logic q_valid;
	op_t  q_head;
	logic q_pop;
	logic clearing;
	logic out_kind;
	logic [93:0] out_data;

	// The input side waits only for room in the queue and for the table clear.
	assign s_axis_tready = !q_full && !clearing;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ugl_front #(
		.GLYPH_ENTRIES(GLYPH_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (s_axis_tuser),
		.glyph_slot   (s_axis_tdata[9:0]),
		.glyph_visible(s_axis_tdata[10]),
		.glyph_advance($signed(s_axis_tdata[22:11])),
		.glyph_width  (s_axis_tdata[32:23]),
		.glyph_height (s_axis_tdata[42:33]),
		.bearing_x    ($signed(s_axis_tdata[53:43])),
		.bearing_y    ($signed(s_axis_tdata[64:54])),
		.start_x      ($signed(s_axis_tdata[80:65])),
		.start_y      ($signed(s_axis_tdata[96:81])),
		.text_byte    (s_axis_tdata[104:97]),
		.utf8_mode    (utf8_mode_q),
		.push         (push),
		.entry        (push_entry)
	);

	ugl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	ugl_back #(
		.GLYPH_ENTRIES(GLYPH_ENTRIES),
		.COORD_BITS   (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.line_height(line_height_q),
		.clearing   (clearing),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (out_kind),
		.out_data   (out_data)
	);

	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = {2'b00, out_data};

endmodule

`default_nettype wire
